### sv/duhp_pkg.sv
// Shared types, character codes and helper functions for the data URI header parser.
`timescale 1ns / 1ps

package duhp_pkg;

    localparam int MAX_MIME_LENGTH_DEFAULT = 255;

    localparam logic [15:0] CH_NUL     = 16'h0000;
    localparam logic [15:0] CH_PLUS    = 16'h002B;
    localparam logic [15:0] CH_COMMA   = 16'h002C;
    localparam logic [15:0] CH_DASH    = 16'h002D;
    localparam logic [15:0] CH_DOT     = 16'h002E;
    localparam logic [15:0] CH_SLASH   = 16'h002F;
    localparam logic [15:0] CH_DIGIT_0 = 16'h0030;
    localparam logic [15:0] CH_DIGIT_4 = 16'h0034;
    localparam logic [15:0] CH_DIGIT_6 = 16'h0036;
    localparam logic [15:0] CH_DIGIT_9 = 16'h0039;
    localparam logic [15:0] CH_COLON   = 16'h003A;
    localparam logic [15:0] CH_SEMI    = 16'h003B;
    localparam logic [15:0] CH_EQUAL   = 16'h003D;
    localparam logic [15:0] CH_UPPER_A = 16'h0041;
    localparam logic [15:0] CH_UPPER_Z = 16'h005A;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;
    localparam logic [15:0] CH_LOWER_B = 16'h0062;
    localparam logic [15:0] CH_LOWER_D = 16'h0064;
    localparam logic [15:0] CH_LOWER_E = 16'h0065;
    localparam logic [15:0] CH_LOWER_S = 16'h0073;
    localparam logic [15:0] CH_LOWER_T = 16'h0074;
    localparam logic [15:0] CH_LOWER_Z = 16'h007A;

    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [2:0] EXT_LEN    = 3'd6;

    typedef enum logic [7:0] {
        PH_PREFIX  = 8'b0000_0001,
        PH_MSTART  = 8'b0000_0010,
        PH_TYPE    = 8'b0000_0100,
        PH_SUBTYPE = 8'b0000_1000,
        PH_TOKEN   = 8'b0001_0000,
        PH_VALUE   = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_REJECT  = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        ST_SCAN    = 2'd0,
        ST_DONE    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_PAYLOAD = 2'd3
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  match_index;
        logic        token_b64;
        logic [7:0]  char_count;
        logic [7:0]  count_at_semi;
        logic        base64_seen;
        logic [7:0]  mime_len;
    } parse_state_t;

    typedef struct packed {
        status_t     status;
        logic        base64_flag;
        logic [7:0]  mime_length;
        logic [15:0] payload_char;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:         PH_PREFIX,
        match_index:   3'd0,
        token_b64:     1'b1,
        char_count:    8'd0,
        count_at_semi: 8'd0,
        base64_seen:   1'b0,
        mime_len:      8'd0
    };

    // "data:"
    function automatic logic [15:0] prefix_char(input logic [2:0] idx);
        logic [15:0] c;
        unique case (idx)
            3'd0:    c = CH_LOWER_D;
            3'd1:    c = CH_LOWER_A;
            3'd2:    c = CH_LOWER_T;
            3'd3:    c = CH_LOWER_A;
            3'd4:    c = CH_COLON;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // "base64"
    function automatic logic [15:0] ext_char(input logic [2:0] idx);
        logic [15:0] c;
        unique case (idx)
            3'd0:    c = CH_LOWER_B;
            3'd1:    c = CH_LOWER_A;
            3'd2:    c = CH_LOWER_S;
            3'd3:    c = CH_LOWER_E;
            3'd4:    c = CH_DIGIT_6;
            3'd5:    c = CH_DIGIT_4;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_lower(input logic [15:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_upper(input logic [15:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_subtype_char(input logic [15:0] c);
        return is_lower(c) || is_digit(c) || (c == CH_DASH) || (c == CH_DOT)
            || (c == CH_PLUS);
    endfunction

    function automatic logic is_token_char(input logic [15:0] c);
        return is_lower(c) || is_upper(c) || is_digit(c) || (c == CH_DASH);
    endfunction

endpackage

### sv/duhp_in_if.sv
// Character input channel: valid/ready with one URI character per transfer.
`timescale 1ns / 1ps

interface duhp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        first_of_url;

    modport source (output valid, output char_code, output first_of_url, input ready);
    modport sink   (input valid, input char_code, input first_of_url, output ready);
endinterface

### sv/duhp_out_if.sv
// Result output channel: valid/ready with one status item per transfer.
`timescale 1ns / 1ps

interface duhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        base64_flag;
    logic [7:0]  mime_length;
    logic [15:0] payload_char;

    modport source (output valid, output status, output base64_flag, output mime_length,
                    output payload_char, input ready);
    modport sink   (input valid, input status, input base64_flag, input mime_length,
                    input payload_char, output ready);
endinterface

### sv/duhp_step.sv
// Next-state and result logic of the header recognizer for one character.
`timescale 1ns / 1ps

module duhp_step #(
    parameter int MAX_MIME_LENGTH = duhp_pkg::MAX_MIME_LENGTH_DEFAULT
) (
    input  duhp_pkg::parse_state_t state,
    input  logic [15:0]            char_code,
    input  logic                   first_of_url,
    output duhp_pkg::parse_state_t state_next,
    output duhp_pkg::result_t      result
);

    localparam logic [7:0] LEN_LIMIT = (MAX_MIME_LENGTH > 255) ? 8'd255
                                                               : 8'(MAX_MIME_LENGTH);

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v < LEN_LIMIT) ? v + 8'd1 : v;
    endfunction

    duhp_pkg::parse_state_t cur;
    duhp_pkg::parse_state_t nxt;
    duhp_pkg::status_t      status;
    logic [15:0]            pass;
    logic [15:0]            c;

    always_comb
    begin
        c      = char_code;
        cur    = first_of_url ? duhp_pkg::STATE_RESET : state;
        nxt    = cur;
        status = duhp_pkg::ST_SCAN;
        pass   = '0;

        unique case (cur.phase)
            duhp_pkg::PH_PREFIX:
            begin
                if (cur.match_index < duhp_pkg::PREFIX_LEN
                    && c == duhp_pkg::prefix_char(cur.match_index))
                begin
                    if (cur.match_index == duhp_pkg::PREFIX_LEN - 3'd1)
                    begin
                        nxt.match_index = 3'd0;
                        nxt.phase       = duhp_pkg::PH_MSTART;
                    end
                    else
                    begin
                        nxt.match_index = cur.match_index + 3'd1;
                    end
                end
                else
                begin
                    nxt.phase = duhp_pkg::PH_REJECT;
                end
            end
            duhp_pkg::PH_MSTART:
            begin
                priority if (c == duhp_pkg::CH_SEMI)
                begin
                    nxt.count_at_semi = cur.char_count;
                    nxt.char_count    = bump(cur.char_count);
                    nxt.match_index   = 3'd0;
                    nxt.token_b64     = 1'b1;
                    nxt.phase         = duhp_pkg::PH_TOKEN;
                end
                else if (c == duhp_pkg::CH_COMMA)
                begin
                    nxt.mime_len    = 8'd0;
                    nxt.base64_seen = 1'b0;
                    nxt.phase       = duhp_pkg::PH_PAYLOAD;
                    status          = duhp_pkg::ST_DONE;
                end
                else if (duhp_pkg::is_lower(c))
                begin
                    nxt.char_count = bump(cur.char_count);
                    nxt.phase      = duhp_pkg::PH_TYPE;
                end
                else if (c == duhp_pkg::CH_SLASH)
                begin
                    nxt.char_count = bump(cur.char_count);
                    nxt.phase      = duhp_pkg::PH_SUBTYPE;
                end
                else
                begin
                    nxt.phase = duhp_pkg::PH_REJECT;
                end
            end
            duhp_pkg::PH_TYPE:
            begin
                priority if (duhp_pkg::is_lower(c))
                begin
                    nxt.char_count = bump(cur.char_count);
                end
                else if (c == duhp_pkg::CH_SLASH)
                begin
                    nxt.char_count = bump(cur.char_count);
                    nxt.phase      = duhp_pkg::PH_SUBTYPE;
                end
                else
                begin
                    nxt.phase = duhp_pkg::PH_REJECT;
                end
            end
            duhp_pkg::PH_SUBTYPE:
            begin
                priority if (duhp_pkg::is_subtype_char(c))
                begin
                    nxt.char_count = bump(cur.char_count);
                end
                else if (c == duhp_pkg::CH_SEMI)
                begin
                    nxt.count_at_semi = cur.char_count;
                    nxt.char_count    = bump(cur.char_count);
                    nxt.match_index   = 3'd0;
                    nxt.token_b64     = 1'b1;
                    nxt.phase         = duhp_pkg::PH_TOKEN;
                end
                else if (c == duhp_pkg::CH_COMMA)
                begin
                    nxt.mime_len    = cur.char_count;
                    nxt.base64_seen = 1'b0;
                    nxt.phase       = duhp_pkg::PH_PAYLOAD;
                    status          = duhp_pkg::ST_DONE;
                end
                else
                begin
                    nxt.phase = duhp_pkg::PH_REJECT;
                end
            end
            duhp_pkg::PH_TOKEN:
            begin
                priority if (duhp_pkg::is_token_char(c))
                begin
                    nxt.char_count = bump(cur.char_count);
                    if (cur.token_b64 && cur.match_index < duhp_pkg::EXT_LEN
                        && c == duhp_pkg::ext_char(cur.match_index))
                    begin
                        nxt.match_index = cur.match_index + 3'd1;
                    end
                    else
                    begin
                        nxt.token_b64 = 1'b0;
                    end
                end
                else if (c == duhp_pkg::CH_COMMA)
                begin
                    // bare token before the comma must be exactly the base64 extension
                    if (cur.token_b64 && cur.match_index == duhp_pkg::EXT_LEN)
                    begin
                        nxt.mime_len    = cur.count_at_semi;
                        nxt.base64_seen = 1'b1;
                        nxt.phase       = duhp_pkg::PH_PAYLOAD;
                        status          = duhp_pkg::ST_DONE;
                    end
                    else
                    begin
                        nxt.phase = duhp_pkg::PH_REJECT;
                    end
                end
                else if (c == duhp_pkg::CH_EQUAL)
                begin
                    nxt.char_count = bump(cur.char_count);
                    nxt.phase      = duhp_pkg::PH_VALUE;
                end
                else
                begin
                    nxt.phase = duhp_pkg::PH_REJECT;
                end
            end
            duhp_pkg::PH_VALUE:
            begin
                priority if (c == duhp_pkg::CH_SEMI)
                begin
                    nxt.count_at_semi = cur.char_count;
                    nxt.char_count    = bump(cur.char_count);
                    nxt.match_index   = 3'd0;
                    nxt.token_b64     = 1'b1;
                    nxt.phase         = duhp_pkg::PH_TOKEN;
                end
                else if (c == duhp_pkg::CH_COMMA)
                begin
                    nxt.mime_len    = cur.char_count;
                    nxt.base64_seen = 1'b0;
                    nxt.phase       = duhp_pkg::PH_PAYLOAD;
                    status          = duhp_pkg::ST_DONE;
                end
                else if (c == duhp_pkg::CH_NUL)
                begin
                    nxt.phase = duhp_pkg::PH_REJECT;
                end
                else
                begin
                    nxt.char_count = bump(cur.char_count);
                end
            end
            duhp_pkg::PH_PAYLOAD:
            begin
                status = duhp_pkg::ST_PAYLOAD;
                pass   = c;
            end
            default:
            begin
                nxt.phase = duhp_pkg::PH_REJECT;
            end
        endcase

        if (nxt.phase == duhp_pkg::PH_REJECT)
        begin
            status = duhp_pkg::ST_REJECT;
        end

        state_next          = nxt;
        result.status       = status;
        result.base64_flag  = nxt.base64_seen;
        result.mime_length  = nxt.mime_len;
        result.payload_char = pass;
    end

endmodule

### sv/data_uri_header_parser_core.sv
// Data URI header parser: one character in, one status result out per transfer.
// Each character passes the input register, then the result register; a stalled result
// register holds the character in the input register until the receiver takes a result.
// Throughput: one character per cycle unless results.ready stalls; the phase register updates once per character.
// The result register holds a finished item while the next one is taken in.
// Reset (rst_n low, asynchronous) clears both stages and returns the parser to the prefix.
`timescale 1ns / 1ps

module data_uri_header_parser_core #(
    parameter int MAX_MIME_LENGTH = duhp_pkg::MAX_MIME_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    duhp_in_if.sink     chars,
    duhp_out_if.source  results
);

    logic                   hold_valid_reg;
    logic [15:0]            hold_char_reg;
    logic                   hold_first_reg;
    duhp_pkg::parse_state_t state_reg;
    logic                   out_valid_reg;
    duhp_pkg::result_t      out_data_reg;

    duhp_pkg::parse_state_t state_next;
    duhp_pkg::result_t      step_result;
    logic                   advance;
    logic                   fire;
    logic                   take;

    assign advance     = !out_valid_reg || results.ready;
    assign fire        = hold_valid_reg && advance;
    assign chars.ready = !hold_valid_reg || advance;
    assign take        = chars.valid && chars.ready;

    duhp_step #(
        .MAX_MIME_LENGTH (MAX_MIME_LENGTH)
    ) u_step (
        .state        (state_reg),
        .char_code    (hold_char_reg),
        .first_of_url (hold_first_reg),
        .state_next   (state_next),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= duhp_pkg::STATE_RESET;
        end
        else
        begin
            if (chars.ready)
            begin
                hold_valid_reg <= chars.valid;
            end
            if (advance)
            begin
                out_valid_reg <= hold_valid_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_char_reg  <= chars.char_code;
            hold_first_reg <= chars.first_of_url;
        end
        if (fire)
        begin
            out_data_reg <= step_result;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status       = out_data_reg.status;
    assign results.base64_flag  = out_data_reg.base64_flag;
    assign results.mime_length  = out_data_reg.mime_length;
    assign results.payload_char = out_data_reg.payload_char;

endmodule

### dv/tb_data_uri_header_parser_core.sv
// Testbench for data_uri_header_parser_core: directed and random URI streams checked against a header predictor.
`timescale 1ns / 1ps

module tb_data_uri_header_parser_core;
    import duhp_pkg::*;

    localparam int MIME_MAX    = MAX_MIME_LENGTH_DEFAULT;
    localparam int LEN_CAP     = (MIME_MAX > 255) ? 255 : MIME_MAX;
    localparam int PHASE_ITEMS = 325;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    duhp_in_if  chars ();
    duhp_out_if results ();

    data_uri_header_parser_core #(
        .MAX_MIME_LENGTH(MIME_MAX)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    logic [15:0] prefix_word [5] = '{CH_LOWER_D, CH_LOWER_A, CH_LOWER_T, CH_LOWER_A, CH_COLON};
    logic [15:0] ext_word [6]    = '{CH_LOWER_B, CH_LOWER_A, CH_LOWER_S, CH_LOWER_E,
                                     CH_DIGIT_6, CH_DIGIT_4};

    // Tracks the header grammar per character and holds the results still owed by the block.
    class header_scoreboard;
        phase_t      phase;
        logic [2:0]  pos;
        logic        b64_match;
        logic [7:0]  count;
        logic [7:0]  semi_count;
        logic        b64_seen;
        logic [7:0]  mime_len;
        result_t     pending_results[$];
        int          mismatches;

        function new();
            clear_parse();
            mismatches = 0;
        endfunction

        function void clear_parse();
            phase      = PH_PREFIX;
            pos        = 3'd0;
            b64_match  = 1'b1;
            count      = 8'd0;
            semi_count = 8'd0;
            b64_seen   = 1'b0;
            mime_len   = 8'd0;
        endfunction

        function logic is_az(logic [15:0] c);
            return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
        endfunction

        function logic is_caps(logic [15:0] c);
            return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
        endfunction

        function logic is_num(logic [15:0] c);
            return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
        endfunction

        function void bump_count();
            if (count < LEN_CAP)
                count++;
        endfunction

        function void open_token();
            semi_count = count;
            bump_count();
            pos        = 3'd0;
            b64_match  = 1'b1;
            phase      = PH_TOKEN;
        endfunction

        function void close_header(logic [7:0] len, logic b64);
            mime_len = len;
            b64_seen = b64;
            phase    = PH_PAYLOAD;
        endfunction

        function void take_char(logic [15:0] c, logic restart);
            result_t r;
            r.status       = ST_SCAN;
            r.payload_char = 16'd0;
            if (restart)
                clear_parse();
            case (phase)
                PH_PREFIX:
                begin
                    if (pos < 3'd5 && c == prefix_word[pos])
                    begin
                        pos++;
                        if (pos == 3'd5)
                        begin
                            pos   = 3'd0;
                            phase = PH_MSTART;
                        end
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_MSTART:
                begin
                    if (c == CH_SEMI)
                        open_token();
                    else if (c == CH_COMMA)
                    begin
                        close_header(8'd0, 1'b0);
                        r.status = ST_DONE;
                    end
                    else if (is_az(c))
                    begin
                        bump_count();
                        phase = PH_TYPE;
                    end
                    else if (c == CH_SLASH)
                    begin
                        bump_count();
                        phase = PH_SUBTYPE;
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_TYPE:
                begin
                    if (is_az(c))
                        bump_count();
                    else if (c == CH_SLASH)
                    begin
                        bump_count();
                        phase = PH_SUBTYPE;
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_SUBTYPE:
                begin
                    if (is_az(c) || is_num(c) || c == CH_DASH || c == CH_DOT || c == CH_PLUS)
                        bump_count();
                    else if (c == CH_SEMI)
                        open_token();
                    else if (c == CH_COMMA)
                    begin
                        close_header(count, 1'b0);
                        r.status = ST_DONE;
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_TOKEN:
                begin
                    if (is_az(c) || is_caps(c) || is_num(c) || c == CH_DASH)
                    begin
                        bump_count();
                        if (b64_match && pos < 3'd6 && c == ext_word[pos])
                            pos++;
                        else
                            b64_match = 1'b0;
                    end
                    else if (c == CH_COMMA)
                    begin
                        // a bare token is only legal when it spells the extension exactly
                        if (b64_match && pos == 3'd6)
                        begin
                            close_header(semi_count, 1'b1);
                            r.status = ST_DONE;
                        end
                        else
                            phase = PH_REJECT;
                    end
                    else if (c == CH_EQUAL)
                    begin
                        bump_count();
                        phase = PH_VALUE;
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_VALUE:
                begin
                    if (c == CH_SEMI)
                        open_token();
                    else if (c == CH_COMMA)
                    begin
                        close_header(count, 1'b0);
                        r.status = ST_DONE;
                    end
                    else if (c == CH_NUL)
                        phase = PH_REJECT;
                    else
                        bump_count();
                end
                PH_PAYLOAD:
                begin
                    r.status       = ST_PAYLOAD;
                    r.payload_char = c;
                end
                default:
                    phase = PH_REJECT;
            endcase
            if (phase == PH_REJECT)
                r.status = ST_REJECT;
            r.base64_flag = b64_seen;
            r.mime_length = mime_len;
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.base64_flag !== want.base64_flag)
            begin
                $error("base64_flag: expected %0d, got %0d", want.base64_flag, got.base64_flag);
                mismatches++;
            end
            if (got.mime_length !== want.mime_length)
            begin
                $error("mime_length: expected %0d, got %0d", want.mime_length, got.mime_length);
                mismatches++;
            end
            if (got.payload_char !== want.payload_char)
            begin
                $error("payload_char: expected %h, got %h", want.payload_char, got.payload_char);
                mismatches++;
            end
        endfunction
    endclass

    header_scoreboard sb = new();

    logic [15:0] uri_buf[$];
    int          sent;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          hold_start;
    int          cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("data_uri_header_parser_core verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && results.valid && results.ready)
        begin
            got.status       = status_t'(results.status);
            got.base64_flag  = results.base64_flag;
            got.mime_length  = results.mime_length;
            got.payload_char = results.payload_char;
            sb.check_result(got);
        end
    end

    task automatic send_char(input logic [15:0] c, input logic restart);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid        <= 1'b1;
        chars.char_code    <= c;
        chars.first_of_url <= restart;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        sb.take_char(c, restart);
        sent++;
    endtask

    task automatic send_uri(input logic restart);
        for (int i = 0; i < uri_buf.size(); i++)
            send_char(uri_buf[i], (i == 0) ? restart : 1'b0);
    endtask

    task automatic wait_drained();
        chars.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_lower();
        return CH_LOWER_A + 16'($urandom_range(25));
    endfunction

    function automatic logic [15:0] rand_subtype();
        case ($urandom_range(4))
            0:       return CH_DIGIT_0 + 16'($urandom_range(9));
            1:       return CH_DASH;
            2:       return CH_DOT;
            3:       return CH_PLUS;
            default: return rand_lower();
        endcase
    endfunction

    function automatic logic [15:0] rand_token();
        case ($urandom_range(4))
            0:       return CH_UPPER_A + 16'($urandom_range(25));
            1:       return CH_DIGIT_0 + 16'($urandom_range(9));
            2:       return CH_DASH;
            default: return rand_lower();
        endcase
    endfunction

    function automatic logic [15:0] rand_value();
        logic [15:0] c;
        do
        begin
            if ($urandom_range(9) == 0)
                c = 16'($urandom_range(65535));
            else
                c = 16'($urandom_range(126, 32));
        end
        while (c == CH_NUL || c == CH_SEMI || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [15:0] rand_noise();
        case ($urandom_range(11))
            0:       return CH_COMMA;
            1:       return CH_SEMI;
            2:       return CH_EQUAL;
            3:       return CH_SLASH;
            4:       return CH_COLON;
            5:       return CH_NUL;
            6:       return CH_UPPER_A + 16'($urandom_range(25));
            7:       return CH_DIGIT_0 + 16'($urandom_range(9));
            8:       return rand_lower();
            9:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_prefix();
        foreach (prefix_word[i])
            uri_buf.push_back(prefix_word[i]);
    endtask

    task automatic build_header_uri(input bit long_value);
        int n_par;
        int sel;
        int n_val;
        uri_buf.delete();
        push_prefix();
        // about one in seven takes the default media type
        if ($urandom_range(99) >= 15)
        begin
            repeat ($urandom_range(4))
                uri_buf.push_back(rand_lower());
            uri_buf.push_back(CH_SLASH);
            repeat ($urandom_range(5))
                uri_buf.push_back(rand_subtype());
        end
        n_par = long_value ? 1 + $urandom_range(2) : $urandom_range(3);
        for (int i = 0; i < n_par; i++)
        begin
            uri_buf.push_back(CH_SEMI);
            if ($urandom_range(9) == 0)
                foreach (ext_word[k])
                    uri_buf.push_back(ext_word[k]);
            else
                repeat ($urandom_range(5, 1))
                    uri_buf.push_back(rand_token());
            uri_buf.push_back(CH_EQUAL);
            n_val = (long_value && i == 0) ? 260 : $urandom_range(6);
            repeat (n_val)
                uri_buf.push_back(rand_value());
        end
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            uri_buf.push_back(CH_SEMI);
            foreach (ext_word[k])
                uri_buf.push_back(ext_word[k]);
        end
        else if (sel < 50)
        begin
            uri_buf.push_back(CH_SEMI);
            repeat ($urandom_range(6, 1))
                uri_buf.push_back(rand_token());
        end
        else if (sel < 56)
        begin
            // truncated extension, possibly empty
            uri_buf.push_back(CH_SEMI);
            sel = $urandom_range(5);
            for (int k = 0; k < sel; k++)
                uri_buf.push_back(ext_word[k]);
        end
        uri_buf.push_back(CH_COMMA);
        repeat ($urandom_range(6))
            uri_buf.push_back(16'($urandom_range(65535)));
    endtask

    task automatic mutate_uri();
        int pos;
        int sel;
        pos = $urandom_range(uri_buf.size() - 1);
        sel = $urandom_range(99);
        if (sel < 50)
            uri_buf[pos] = rand_noise();
        else if (sel < 75)
            uri_buf.insert(pos, CH_NUL);
        else
            uri_buf = uri_buf[0:pos];
    endtask

    task automatic run_directed();
        // default type, payload extremes; first URI after reset needs no restart
        uri_buf.delete();
        push_prefix();
        uri_buf.push_back(CH_COMMA);
        uri_buf.push_back(16'hFFFF);
        uri_buf.push_back(CH_NUL);
        send_uri(1'b0);
        // bare extension with default type
        uri_buf.delete();
        push_prefix();
        uri_buf.push_back(CH_SEMI);
        foreach (ext_word[k])
            uri_buf.push_back(ext_word[k]);
        uri_buf.push_back(CH_COMMA);
        send_uri(1'b1);
        // NUL inside the prefix, then the reject state holds
        uri_buf.delete();
        for (int k = 0; k < 3; k++)
            uri_buf.push_back(prefix_word[k]);
        uri_buf.push_back(CH_NUL);
        uri_buf.push_back(CH_LOWER_A);
        send_uri(1'b1);
        // empty type and subtype
        uri_buf.delete();
        push_prefix();
        uri_buf.push_back(CH_SLASH);
        uri_buf.push_back(CH_COMMA);
        send_uri(1'b1);
    endtask

    task automatic run_random(input int stop_at);
        int n_uri;
        int sel;
        n_uri = 0;
        while (sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 6)
            begin
                uri_buf.delete();
                repeat ($urandom_range(8, 1))
                    uri_buf.push_back(rand_noise());
            end
            else
            begin
                build_header_uri(n_uri % 40 == 10);
                if (sel < 30)
                    mutate_uri();
            end
            send_uri($urandom_range(9) != 0);
            n_uri++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        chars.valid        = 1'b0;
        chars.char_code    = 16'd0;
        chars.first_of_url = 1'b0;
        results.ready      = 1'b0;
        sent               = 0;
        cycles             = 0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        hold_start         = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 60;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 60;
                end
                default:
                begin
                    tx_idle_pct  = 30;
                    rx_stall_pct = 30;
                end
            endcase
            if (ph == 0)
            begin
                run_directed();
                // long receiver hold-off while characters keep coming
                hold_start = 1'b1;
            end
            run_random((ph + 1) * PHASE_ITEMS);
            wait_drained();
        end

        repeat (10)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("data_uri_header_parser_core verification clean");
        else
            $display("data_uri_header_parser_core verification failed");
        $finish;
    end

endmodule

### sim.f
sv/duhp_pkg.sv
sv/duhp_in_if.sv
sv/duhp_out_if.sv
sv/duhp_step.sv
sv/data_uri_header_parser_core.sv
dv/tb_data_uri_header_parser_core.sv
